/* rtl/lrc_pkg.sv */
// Package for the LRU replacement cache unit: sizes, controller state type,
// command and status structs, capacity clamp function.
// No dependencies.
package lrc_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_BITS  = 16;
  localparam int CFG_W    = 5;
  localparam int CNT_W    = 32;
  localparam int CAP_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic [CAP_W-1:0] eff_cap(input logic [CFG_W-1:0] c);
    logic [CAP_W-1:0] r;
    if (c == '0) begin
      r = CAP_W'(1);
    end else if (int'(c) > CAPACITY) begin
      r = CAP_W'(CAPACITY);
    end else begin
      r = CAP_W'(c);
    end
    return r;
  endfunction

endpackage

/* rtl/lrc_if.sv */
// Channel interfaces for the LRU replacement cache unit: access input and
// result output, valid/ready handshake. Depends on lrc_pkg.
interface lrc_in_if;
  import lrc_pkg::*;
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] access_id;
  logic               start_trace;
  logic               final_access;

  modport source (output valid, output access_id, output start_trace,
                  output final_access, input ready);
  modport sink   (input valid, input access_id, input start_trace,
                  input final_access, output ready);
endinterface

interface lrc_out_if;
  import lrc_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               evict_valid;
  logic [ID_BITS-1:0] evicted_id;
  logic [CNT_W-1:0]   miss_total;
  logic               trace_done;

  modport source (output valid, output hit, output evict_valid, output evicted_id,
                  output miss_total, output trace_done, input ready);
  modport sink   (input valid, input hit, input evict_valid, input evicted_id,
                  input miss_total, input trace_done, output ready);
endinterface

/* rtl/lru_replacement_cache_unit.sv */
// LRU replacement cache unit: fully associative, recency-ordered tag lines.
// An accepted transaction is captured, then updated into the result register (valid).
// The capture/update sequencer around the single tag compare-and-shift step takes no
// new transaction until that update; a waiting result holds the captured transaction
// in update, and input stalls until the result is taken.
// Reset: synchronous, active low; lines empty, miss count zero, capacity 16.
// Depends on lrc_pkg, lrc_if, lrc_ctrl, lrc_dp.
module lru_replacement_cache_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  lrc_in_if.sink                    in_ch,
  lrc_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [lrc_pkg::CFG_W-1:0] cfg_wdata
);
  import lrc_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  lrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lrc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .access_id    (in_ch.access_id),
    .start_trace  (in_ch.start_trace),
    .final_access (in_ch.final_access),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .hit          (out_ch.hit),
    .evict_valid  (out_ch.evict_valid),
    .evicted_id   (out_ch.evicted_id),
    .miss_total   (out_ch.miss_total),
    .trace_done   (out_ch.trace_done)
  );

endmodule

/* rtl/lrc_ctrl.sv */
// Controller for the LRU replacement cache unit: capture/update sequencer.
// Depends on lrc_pkg.
module lrc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lrc_pkg::status_t status,
  output lrc_pkg::cmd_t    cmd
);
  import lrc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/lrc_dp.sv */
// Datapath for the LRU replacement cache unit: recency-ordered tag registers,
// parallel compare, shift update, counters and result register. Depends on lrc_pkg.
module lrc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lrc_pkg::cmd_t                 cmd,
  output lrc_pkg::status_t              status,
  input  logic                          cfg_we,
  input  logic [lrc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [lrc_pkg::ID_BITS-1:0]   access_id,
  input  logic                          start_trace,
  input  logic                          final_access,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          hit,
  output logic                          evict_valid,
  output logic [lrc_pkg::ID_BITS-1:0]   evicted_id,
  output logic [lrc_pkg::CNT_W-1:0]     miss_total,
  output logic                          trace_done
);
  import lrc_pkg::*;

  logic [CFG_W-1:0]   cap_cfg_r;
  logic [ID_BITS-1:0] tags_r [CAPACITY];
  logic [ID_BITS-1:0] tags_nxt [CAPACITY];
  logic [CAP_W-1:0]   occ_r;
  logic [CAP_W-1:0]   occ_nxt;
  logic [CNT_W-1:0]   miss_r;
  logic [CNT_W-1:0]   miss_nxt;

  logic [ID_BITS-1:0] req_id_r;
  logic               req_start_r;
  logic               req_final_r;

  logic               out_full_r;
  logic               hit_r;
  logic               evict_r;
  logic [ID_BITS-1:0] evicted_r;
  logic [CNT_W-1:0]   miss_out_r;
  logic               done_r;

  logic [CAP_W-1:0]   cap;
  logic [CAP_W-1:0]   occ_base;
  logic [CNT_W-1:0]   miss_base;
  logic [CAPACITY-1:0] match;
  logic               hit_c;
  logic               evict_c;
  logic [IDX_W-1:0]   found;
  logic [CAP_W-1:0]   shift_pos;
  logic [CAP_W-1:0]   write_pos;

  assign status.out_free = !out_full_r || out_ready;

  always_comb begin
    cap       = eff_cap(cap_cfg_r);
    occ_base  = req_start_r ? '0 : occ_r;
    miss_base = req_start_r ? '0 : miss_r;
    for (int k = 0; k < CAPACITY; k++) begin
      match[k] = (CAP_W'(k) < occ_base) && (tags_r[k] == req_id_r);
    end
    hit_c = |match;
    found = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (match[k]) begin
        found = IDX_W'(k);
      end
    end
    evict_c = !hit_c && (occ_base >= cap);
    if (hit_c) begin
      shift_pos = CAP_W'(found);
    end else if (evict_c) begin
      shift_pos = '0;
    end else begin
      shift_pos = occ_base;
    end
    write_pos = (hit_c || evict_c) ? occ_base - CAP_W'(1) : occ_base;
    occ_nxt   = (hit_c || evict_c) ? occ_base : occ_base + CAP_W'(1);
    if (hit_c || miss_base == CNT_MAX) begin
      miss_nxt = miss_base;
    end else begin
      miss_nxt = miss_base + CNT_W'(1);
    end
    for (int k = 0; k < CAPACITY; k++) begin
      if (CAP_W'(k) < shift_pos) begin
        tags_nxt[k] = tags_r[k];
      end else if (CAP_W'(k) < write_pos) begin
        tags_nxt[k] = tags_r[(k + 1 < CAPACITY) ? k + 1 : k];
      end else if (CAP_W'(k) == write_pos) begin
        tags_nxt[k] = req_id_r;
      end else begin
        tags_nxt[k] = tags_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_cfg_r  <= CAP_RESET;
      occ_r      <= '0;
      miss_r     <= '0;
      out_full_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_cfg_r <= cfg_wdata;
      end
      if (cmd.update) begin
        occ_r      <= occ_nxt;
        miss_r     <= miss_nxt;
        out_full_r <= 1'b1;
      end else if (out_ready) begin
        out_full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_id_r    <= access_id;
      req_start_r <= start_trace;
      req_final_r <= final_access;
    end
    if (cmd.update) begin
      tags_r     <= tags_nxt;
      hit_r      <= hit_c;
      evict_r    <= evict_c;
      evicted_r  <= evict_c ? tags_r[0] : '0;
      miss_out_r <= miss_nxt;
      done_r     <= req_final_r;
    end
  end

  assign out_valid   = out_full_r;
  assign hit         = hit_r;
  assign evict_valid = evict_r;
  assign evicted_id  = evicted_r;
  assign miss_total  = miss_out_r;
  assign trace_done  = done_r;

endmodule

/* verif/lru_replacement_cache_unit_checker.sv */
// Checker for the LRU replacement cache unit: watches the access and result
// channels and the capacity port, predicts each result and compares it.
// Depends on lrc_pkg and lrc_if.
`timescale 1ns / 100ps

module lru_replacement_cache_unit_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  lrc_in_if                         in_mon,
  lrc_out_if                        out_mon,
  input  logic                      cfg_we,
  input  logic [lrc_pkg::CFG_W-1:0] cfg_wdata,
  output int                        mismatches,
  output int                        results_owed
);
  import lrc_pkg::*;

  typedef struct packed {
    logic               hit;
    logic               evict_valid;
    logic [ID_BITS-1:0] evicted_id;
    logic [CNT_W-1:0]   miss_total;
    logic               trace_done;
  } lru_result_t;

  logic [ID_BITS-1:0] cache_tags [CAPACITY];
  int                 tags_held;
  logic [CNT_W-1:0]   misses;
  logic [CFG_W-1:0]   capacity_reg;
  lru_result_t        owed_results [$];
  lru_result_t        oldest;
  int                 error_total = 0;

  function automatic void remove_line(input int pos);
    for (int k = pos; k + 1 < tags_held; k++) begin
      cache_tags[k] = cache_tags[k + 1];
    end
    if (tags_held > 0) begin
      tags_held--;
    end
  endfunction

  function automatic lru_result_t lru_access(input logic [ID_BITS-1:0] id,
                                             input logic start, input logic fin);
    lru_result_t r;
    int          pos;
    int          cap;
    r   = '0;
    pos = -1;
    cap = (capacity_reg == '0) ? 1 :
          ((int'(capacity_reg) > CAPACITY) ? CAPACITY : int'(capacity_reg));
    if (start) begin
      tags_held = 0;
      misses    = '0;
    end
    for (int k = 0; k < tags_held; k++) begin
      if (pos < 0 && cache_tags[k] == id) begin
        pos = k;
      end
    end
    if (pos >= 0) begin
      r.hit = 1'b1;
      remove_line(pos);
    end else begin
      if (misses != CNT_MAX) begin
        misses++;
      end
      if (tags_held >= cap) begin
        r.evict_valid = 1'b1;
        r.evicted_id  = cache_tags[0];
        remove_line(0);
      end
    end
    if (tags_held < CAPACITY) begin
      cache_tags[tags_held] = id;
      tags_held++;
    end
    r.miss_total = misses;
    r.trace_done = fin;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_total++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tags_held    = 0;
      misses       = '0;
      capacity_reg = CAP_RESET;
      owed_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          $error("result transaction with no access pending");
          error_total++;
        end else begin
          oldest = owed_results.pop_front();
          check_field("hit", CNT_W'(oldest.hit), CNT_W'(out_mon.hit));
          check_field("evict_valid", CNT_W'(oldest.evict_valid), CNT_W'(out_mon.evict_valid));
          check_field("evicted_id", CNT_W'(oldest.evicted_id), CNT_W'(out_mon.evicted_id));
          check_field("miss_total", oldest.miss_total, out_mon.miss_total);
          check_field("trace_done", CNT_W'(oldest.trace_done), CNT_W'(out_mon.trace_done));
        end
      end
      if (cfg_we) begin
        capacity_reg = cfg_wdata;
      end
      if (in_mon.valid && in_mon.ready) begin
        owed_results.push_back(lru_access(in_mon.access_id, in_mon.start_trace,
                                          in_mon.final_access));
      end
    end
    mismatches   <= error_total;
    results_owed <= owed_results.size();
  end

endmodule

/* verif/lru_replacement_cache_unit_tb.sv */
// Testbench top for the LRU replacement cache unit: clock, reset, access
// traces, capacity changes, receiver stalls and the verdict.
// Depends on lrc_pkg, lrc_if, the unit and lru_replacement_cache_unit_checker.
`timescale 1ns / 100ps

module lru_replacement_cache_unit_tb;
  import lrc_pkg::*;

  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 53;
  localparam int HOLD_CYCLES = 80;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               mismatches;
  int               results_owed;
  bit               send_idle;
  bit               recv_idle;
  bit               hold_req;

  lrc_in_if  in_ch ();
  lrc_out_if out_ch ();

  lru_replacement_cache_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lru_replacement_cache_unit_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  always #10 clk = ~clk;

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_access(input logic [ID_BITS-1:0] id, input logic st, input logic fn);
    if (send_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.access_id    <= id;
    in_ch.start_trace  <= st;
    in_ch.final_access <= fn;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] value);
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver side
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req && !held) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if (recv_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    logic [CFG_W-1:0]   phase_caps [NUM_PHASES];
    logic [ID_BITS-1:0] pool [24];
    logic [ID_BITS-1:0] id;
    logic               st;
    logic               fn;
    bit                 well;
    int                 eff;
    int                 tlen;
    int                 wset;
    int                 sent;
    int                 sel;

    phase_caps = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd8, 5'd2, 5'd17, 5'd12, 5'd5};
    send_idle  = 1'b1;
    recv_idle  = 1'b1;
    hold_req   = 1'b0;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.access_id    <= '0;
    in_ch.start_trace  <= 1'b0;
    in_ch.final_access <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // full capacity: extremes of the identifier, hit and plain misses
    set_capacity(5'd16);
    send_access(16'h0000, 1'b1, 1'b0);
    send_access(16'hFFFF, 1'b0, 1'b0);
    send_access(16'h0000, 1'b0, 1'b0);
    send_access(16'hA5A5, 1'b0, 1'b0);
    send_access(16'h5A5A, 1'b0, 1'b1);

    // zero capacity acts as one line
    set_capacity(5'd0);
    send_access(16'h1234, 1'b1, 1'b0);
    send_access(16'h1234, 1'b0, 1'b0);
    send_access(16'h4321, 1'b0, 1'b0);
    send_access(16'h1234, 1'b0, 1'b1);

    // fill three lines, then lower the capacity while they are held
    set_capacity(5'd3);
    send_access(16'h0001, 1'b1, 1'b0);
    send_access(16'h0002, 1'b0, 1'b0);
    send_access(16'h0003, 1'b0, 1'b0);
    send_access(16'h0004, 1'b0, 1'b0);
    set_capacity(5'd1);
    send_access(16'h0005, 1'b0, 1'b0);
    send_access(16'h0003, 1'b0, 1'b0);
    send_access(16'h0006, 1'b0, 1'b1);

    // capacity above the built size, start and end on one access
    set_capacity(5'd31);
    send_access(16'h0007, 1'b1, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_capacity(phase_caps[p]);
      eff = (phase_caps[p] == '0) ? 1 :
            ((int'(phase_caps[p]) > CAPACITY) ? CAPACITY : int'(phase_caps[p]));
      send_idle = (p != NUM_PHASES - 1) && (p != 3) && ($urandom_range(0, 3) != 0);
      recv_idle = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (p == 3) begin
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        tlen = $urandom_range(1, 3 * eff + 4);
        if (tlen > PHASE_ITEMS - sent) begin
          tlen = PHASE_ITEMS - sent;
        end
        wset = $urandom_range(1, eff + 4);
        for (int k = 0; k < wset; k++) begin
          pool[k] = ID_BITS'($urandom);
        end
        well = ($urandom_range(0, 9) != 0);
        for (int j = 0; j < tlen; j++) begin
          if ($urandom_range(0, 7) == 0) begin
            sel = $urandom_range(0, 3);
            id  = (sel == 0) ? '0 : (sel == 1) ? '1 : ID_BITS'($urandom);
          end else begin
            id = pool[$urandom_range(0, wset - 1)];
          end
          st = well ? (j == 0) : ($urandom_range(0, 7) == 0);
          fn = well ? (j == tlen - 1) : ($urandom_range(0, 7) == 0);
          send_access(id, st, fn);
        end
        sent += tlen;
      end
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
